[rtl/mctw_pkg.sv]
// ----------------------------------------------------------------------------
// mctw_pkg: shared types and constants for the multi-channel task watchdog
// Holds the action and event codes, reset defaults and the table entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package mctw_pkg;

    // reset value of both timing registers
    localparam logic [15:0] DEFAULT_PERIOD_MS = 16'd5000;

    // input action codes
    localparam logic [1:0] ACT_TICK      = 2'd0;
    localparam logic [1:0] ACT_REGISTER  = 2'd1;
    localparam logic [1:0] ACT_HEARTBEAT = 2'd2;

    // event kinds
    localparam logic EVT_RESTART = 1'b0;
    localparam logic EVT_SYS_RST = 1'b1;

    // config register indexes (taken from paddr[2])
    localparam logic REG_CHECK_PERIOD  = 1'b0;
    localparam logic REG_INITIAL_DELAY = 1'b1;

    // stream word widths and config address width
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int APB_AW    = 3;

    // one channel entry as kept in the table RAM
    typedef struct packed {
        logic [31:0] timeout;
        logic [31:0] last_beat;
        logic        restartable;
        logic        running;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // one watchdog event
    typedef struct packed {
        logic [3:0]  channel;
        logic        kind;
        logic        delete_task;
        logic [31:0] elapsed;
    } event_t;

endpackage

`default_nettype wire

[rtl/mctw_ram.sv]
// ----------------------------------------------------------------------------
// mctw_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module mctw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/multi_channel_task_watchdog_core.sv]
// ----------------------------------------------------------------------------
// multi_channel_task_watchdog_core: table-based software task watchdog
// Channel table in one RAM, walked by a scan sequencer on check-period ticks.
// ----------------------------------------------------------------------------
// A tick without a scan, a registration or an ignored word is taken in ST_IDLE
// alone. A heartbeat to a registered channel is a read-modify-write through the
// single read port: ST_IDLE, then ST_HB_WR. A scan tick walks ST_SCAN_RD for each
// entry, ST_SCAN_EV per registered one, ST_FLUSH; the event output can stall it.
// Items are taken one at a time; results leave through an output register. Reset
// is synchronous: valid bits, timers and control registers clear; the RAM is not cleared.
`default_nettype none

module multi_channel_task_watchdog_core #(
    parameter int MAX_CHANNELS = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [3:0] channel, [35:4] timeout_ms, [36] has_restart, [37] task_running
    input  wire logic [mctw_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] action
    input  wire logic [1:0]                      s_tuser,
    // event stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [3:0] expired_channel, [4] delete_task, [36:5] elapsed_ms
    output logic      [mctw_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] event_kind
    output logic      [0:0]                      m_tuser,
    output logic                                 m_tlast,
    // config port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mctw_pkg::APB_AW-1:0]     paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);

    import mctw_pkg::*;

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [CH_W:0] IDX_END = (CH_W+1)'(MAX_CHANNELS);
    localparam logic [CH_W:0] IDX_ONE = (CH_W+1)'(1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_HB_WR   = 3'd1;
    localparam logic [2:0] ST_SCAN_RD = 3'd2;
    localparam logic [2:0] ST_SCAN_EV = 3'd3;
    localparam logic [2:0] ST_FLUSH   = 3'd4;

    // registers
    logic [2:0]              state_reg, state_next;
    logic [CH_W:0]           idx_reg, idx_next;
    logic [MAX_CHANNELS-1:0] valid_reg, valid_next;
    logic [15:0]             period_reg, period_next;
    logic [15:0]             delay_reg, delay_next;
    logic [31:0]             now_reg, now_next;
    logic [15:0]             countdown_reg, countdown_next;
    logic                    pend_valid_reg, pend_valid_next;
    event_t                  pend_reg, pend_next;
    logic                    out_valid_reg, out_valid_next;
    event_t                  out_reg, out_next;
    logic                    out_last_reg, out_last_next;

    // RAM ports
    logic                    ram_we, ram_re;
    logic [CH_W-1:0]         ram_waddr, ram_raddr;
    entry_t                  ram_wdata, ram_rdata;

    // input word fields
    logic [1:0]              in_action;
    logic [3:0]              in_channel;
    logic [31:0]             in_timeout;
    logic                    in_restart, in_running;
    logic                    in_ch_ok;
    logic [CH_W-1:0]         in_idx;
    logic                    in_accept;

    // scan evaluation
    logic [CH_W-1:0]         scan_idx;
    logic [31:0]             elapsed;
    logic                    expired;
    logic                    out_free;
    logic                    cfg_write;

    assign in_action  = s_tuser;
    assign in_channel = s_tdata[3:0];
    assign in_timeout = s_tdata[35:4];
    assign in_restart = s_tdata[36];
    assign in_running = s_tdata[37];
    assign in_ch_ok   = (9'(in_channel) < 9'(MAX_CHANNELS));
    assign in_idx     = CH_W'(in_channel);

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign scan_idx = idx_reg[CH_W-1:0];
    assign elapsed  = now_reg - ram_rdata.last_beat;
    assign expired  = (ram_rdata.timeout != 32'd0) && (elapsed > ram_rdata.timeout);
    assign out_free = !out_valid_reg || m_tready;

    assign cfg_write = psel && penable && pwrite && pready;

    // channel table
    mctw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_CHANNELS),
        .AW    (CH_W)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer and datapath next state
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        period_next     = period_reg;
        delay_next      = delay_reg;
        now_next        = now_reg;
        countdown_next  = countdown_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        ram_we    = 1'b0;
        ram_waddr = in_idx;
        ram_wdata = '{timeout: in_timeout, last_beat: now_reg,
                      restartable: in_restart, running: in_running};
        ram_re    = 1'b0;
        ram_raddr = in_idx;

        // config writes must arrive only while idle; the block itself does not enforce it
        if (cfg_write) begin
            if (paddr[2] == REG_CHECK_PERIOD) begin
                period_next = pwdata[15:0];
            end else begin
                delay_next = pwdata[15:0];
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    case (in_action)
                        ACT_TICK: begin
                            now_next = now_reg + 32'd1;
                            if (countdown_reg <= 16'd1) begin
                                countdown_next = period_reg;
                                idx_next       = '0;
                                state_next     = ST_SCAN_RD;
                            end else begin
                                countdown_next = countdown_reg - 16'd1;
                            end
                        end
                        ACT_REGISTER: begin
                            if (in_ch_ok) begin
                                ram_we             = 1'b1;
                                valid_next[in_idx] = 1'b1;
                            end
                        end
                        ACT_HEARTBEAT: begin
                            if (in_ch_ok && valid_reg[in_idx]) begin
                                ram_re     = 1'b1;
                                idx_next   = (CH_W+1)'(in_idx);
                                state_next = ST_HB_WR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // restamp the heartbeat, keep the rest of the entry
            ST_HB_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = scan_idx;
                ram_wdata  = ram_rdata;
                ram_wdata.last_beat = now_reg;
                state_next = ST_IDLE;
            end

            // skip unregistered entries, read registered ones
            ST_SCAN_RD: begin
                ram_raddr = scan_idx;
                if (idx_reg == IDX_END) begin
                    state_next = ST_FLUSH;
                end else if (valid_reg[scan_idx]) begin
                    ram_re     = 1'b1;
                    state_next = ST_SCAN_EV;
                end else begin
                    idx_next = idx_reg + IDX_ONE;
                end
            end

            // check one entry; an event waits in pend until the next is known
            ST_SCAN_EV: begin
                if (!expired) begin
                    idx_next   = idx_reg + IDX_ONE;
                    state_next = ST_SCAN_RD;
                end else if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        out_next       = pend_reg;
                        out_last_next  = 1'b0;
                        out_valid_next = 1'b1;
                    end
                    pend_valid_next     = 1'b1;
                    pend_next.channel   = 4'(scan_idx);
                    pend_next.elapsed   = elapsed;
                    if (ram_rdata.restartable) begin
                        pend_next.kind        = EVT_RESTART;
                        pend_next.delete_task = ram_rdata.running;
                        ram_we     = 1'b1;
                        ram_waddr  = scan_idx;
                        ram_wdata  = ram_rdata;
                        ram_wdata.last_beat = now_reg;
                        ram_wdata.running   = 1'b0;
                        idx_next   = idx_reg + IDX_ONE;
                        state_next = ST_SCAN_RD;
                    end else begin
                        // system reset: valid bits, timing registers and timers back to reset values
                        pend_next.kind        = EVT_SYS_RST;
                        pend_next.delete_task = 1'b0;
                        valid_next     = '0;
                        period_next    = DEFAULT_PERIOD_MS;
                        delay_next     = DEFAULT_PERIOD_MS;
                        now_next       = 32'd0;
                        countdown_next = DEFAULT_PERIOD_MS;
                        state_next     = ST_FLUSH;
                    end
                end
            end

            // last event of the scan leaves with tlast set
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // register update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            valid_reg      <= '0;
            period_reg     <= DEFAULT_PERIOD_MS;
            delay_reg      <= DEFAULT_PERIOD_MS;
            now_reg        <= 32'd0;
            countdown_reg  <= DEFAULT_PERIOD_MS;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            valid_reg      <= valid_next;
            period_reg     <= period_next;
            delay_reg      <= delay_next;
            now_reg        <= now_next;
            countdown_reg  <= countdown_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    // outputs
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {3'b000, out_reg.elapsed, out_reg.delete_task, out_reg.channel};
    assign m_tuser[0] = out_reg.kind;
    assign m_tlast    = out_last_reg;

    // register readback
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_INITIAL_DELAY) ? {16'd0, delay_reg}
                                                    : {16'd0, period_reg};

endmodule

`default_nettype wire

[tb/multi_channel_task_watchdog_core_tb.sv]
// ----------------------------------------------------------------------------
// multi_channel_task_watchdog_core_tb: self-checking bench for the task watchdog
// Drives tick, register and heartbeat words into the input stream, predicts
// every expiry event from a shadow copy of the channel table and checks each
// event word against it. Timing registers are written and read back between
// phases.
// ----------------------------------------------------------------------------
module multi_channel_task_watchdog_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mctw_pkg::*;

    localparam int NCH           = 16;
    localparam int RANDOM_WORDS  = 260;
    localparam int QUIET_TAIL    = 60;
    localparam int SETTLE_CYCLES = 2 * NCH + 16;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SYSRST_CAP    = 1;
    localparam int LONG_TICKS    = 40;

    localparam logic [APB_AW-1:0] ADDR_PERIOD = {REG_CHECK_PERIOD, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_DELAY  = {REG_INITIAL_DELAY, 2'b00};
    localparam logic [1:0]        ACT_UNUSED  = 2'd3;

    // one expected event word
    typedef struct packed {
        logic [3:0]  channel;
        logic        kind;
        logic        del;
        logic [31:0] elapsed;
        logic        last;
    } wd_event_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [3:0] channel, [35:4] timeout, [36] restart, [37] running
    logic [1:0]           s_tuser;   // [1:0] action
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // [3:0] channel, [4] delete_task, [36:5] elapsed
    logic [0:0]           m_tuser;   // [0] event_kind
    logic                 m_tlast;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    // shadow of the watchdog state
    logic [15:0] period_reg;
    logic [15:0] delay_reg;
    logic [31:0] clk_ms;
    logic [15:0] scan_cnt;
    logic        tbl_valid   [NCH];
    logic [31:0] tbl_timeout [NCH];
    logic [31:0] tbl_beat    [NCH];
    logic        tbl_restart [NCH];
    logic        tbl_running [NCH];

    wd_event_t pending_events[$];
    wd_event_t head_event;

    int  err_count      = 0;
    int  words_sent     = 0;
    int  events_checked = 0;
    int  scans_run      = 0;
    int  restarts_seen  = 0;
    int  sysrst_seen    = 0;
    int  hold_left      = 0;
    int  stall_left     = 0;
    int  quiet_cycles   = 0;
    logic src_idle_on   = 1'b1;
    logic sink_idle_on  = 1'b1;

    multi_channel_task_watchdog_core #(
        .MAX_CHANNELS(NCH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // error reporting
    // ------------------------------------------------------------------
    task automatic report_err(input string msg);
        err_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_err($sformatf("event %0d %s: got 0x%0h, expected 0x%0h",
                                 events_checked, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // shadow table
    // ------------------------------------------------------------------
    // block reset, also taken on a system-reset event
    function automatic void table_reset();
        period_reg = DEFAULT_PERIOD_MS;
        delay_reg  = DEFAULT_PERIOD_MS;
        clk_ms     = '0;
        scan_cnt   = delay_reg;
        for (int i = 0; i < NCH; i++)
            tbl_valid[i] = 1'b0;
    endfunction

    // walk the table in index order and queue the expiry events
    function automatic void scan_table();
        wd_event_t   found[$];
        wd_event_t   ev;
        logic [31:0] el;
        logic        stop;
        stop = 1'b0;
        scans_run++;
        for (int i = 0; i < NCH; i++) begin
            if (!stop && tbl_valid[i]) begin
                el = clk_ms - tbl_beat[i];
                if (tbl_timeout[i] != 32'd0 && el > tbl_timeout[i]) begin
                    ev.channel = 4'(i);
                    ev.elapsed = el;
                    ev.last    = 1'b0;
                    if (tbl_restart[i]) begin
                        ev.kind        = EVT_RESTART;
                        ev.del         = tbl_running[i];
                        tbl_running[i] = 1'b0;
                        tbl_beat[i]    = clk_ms;
                        restarts_seen++;
                    end else begin
                        ev.kind = EVT_SYS_RST;
                        ev.del  = 1'b0;
                        stop    = 1'b1;
                    end
                    found.insert(found.size(), ev);
                end
            end
        end
        if (found.size() > 0) begin
            ev = found[found.size() - 1];
            ev.last = 1'b1;
            found[found.size() - 1] = ev;
        end
        foreach (found[k])
            pending_events.insert(pending_events.size(), found[k]);
        if (stop) begin
            sysrst_seen++;
            table_reset();
        end
    endfunction

    // state update for one accepted input word
    function automatic void watchdog_predict(input logic [1:0] act, input logic [3:0] ch,
                                             input logic [31:0] tmo, input logic rst_ok,
                                             input logic run);
        case (act)
            ACT_TICK: begin
                clk_ms = clk_ms + 32'd1;
                if (scan_cnt <= 16'd1) begin
                    scan_cnt = period_reg;
                    scan_table();
                end else begin
                    scan_cnt = scan_cnt - 16'd1;
                end
            end
            ACT_REGISTER: begin
                tbl_valid[ch]   = 1'b1;
                tbl_timeout[ch] = tmo;
                tbl_beat[ch]    = clk_ms;
                tbl_restart[ch] = rst_ok;
                tbl_running[ch] = run;
            end
            ACT_HEARTBEAT: begin
                if (tbl_valid[ch])
                    tbl_beat[ch] = clk_ms;
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // input stream driver
    // ------------------------------------------------------------------
    task automatic push_word(input logic [1:0] act, input logic [3:0] ch,
                             input logic [31:0] tmo, input logic rst_ok, input logic run);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {2'b00, run, rst_ok, tmo, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        watchdog_predict(act, ch, tmo, rst_ok, run);
        words_sent++;
    endtask

    // tick with junk in the unused fields
    task automatic send_tick();
        push_word(ACT_TICK, 4'($urandom), $urandom, 1'($urandom), 1'($urandom));
    endtask

    task automatic tick_n(input int n);
        repeat (n) send_tick();
    endtask

    // tick until the next tick or the one after it starts a scan
    task automatic wake_up();
        logic keep;
        keep = src_idle_on;
        src_idle_on = 1'b0;
        while (scan_cnt > 16'd2) send_tick();
        src_idle_on = keep;
    endtask

    // stop offering, let every event drain, then let a silent scan finish
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // config port
    // ------------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_expect(input logic [APB_AW-1:0] addr, input logic [15:0] want,
                               input string name);
        logic [31:0] rd;
        apb_access(1'b0, addr, '0, rd);
        if (rd !== {16'h0000, want})
            report_err($sformatf("%s read 0x%0h, expected 0x%0h", name, rd, want));
    endtask

    task automatic check_timing_regs();
        read_expect(ADDR_PERIOD, period_reg, "check_period_ms");
        read_expect(ADDR_DELAY, delay_reg, "initial_delay_ms");
    endtask

    // only with the block idle; upper data bits carry junk the block must drop
    task automatic set_timing(input logic [15:0] per, input logic [15:0] dly);
        logic [31:0] rd;
        wait_drained();
        check_timing_regs();
        apb_access(1'b1, ADDR_PERIOD, {16'($urandom), per}, rd);
        period_reg = per;
        apb_access(1'b1, ADDR_DELAY, {16'($urandom), dly}, rd);
        delay_reg = dly;
        check_timing_regs();
    endtask

    // ------------------------------------------------------------------
    // event checker and receiver ready
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_events.size() == 0) begin
                    report_err($sformatf("event for channel %0d with none pending",
                                         m_tdata[3:0]));
                end else begin
                    head_event = pending_events.pop_front();
                    check_field("expired_channel", 32'(m_tdata[3:0]), 32'(head_event.channel));
                    check_field("event_kind", 32'(m_tuser[0]), 32'(head_event.kind));
                    check_field("delete_task", 32'(m_tdata[4]), 32'(head_event.del));
                    check_field("elapsed_ms", m_tdata[36:5], head_event.elapsed);
                    check_field("last_of_run", 32'(m_tlast), 32'(head_event.last));
                end
                events_checked++;
            end
            // long hold-off first, then short random stalls
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset values, then both registers at their extremes
    task automatic test_register_defaults();
        check_timing_regs();
        set_timing(16'hFFFF, 16'd0);
        set_timing(16'd1, 16'hFFFF);
    endtask

    // field extremes, ignored words, restart and system-reset events
    task automatic test_directed();
        set_timing(16'd3, 16'd1);
        push_word(ACT_REGISTER, 4'd0, 32'd0, 1'b1, 1'b1);            // never checked
        push_word(ACT_REGISTER, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1);   // never expires
        push_word(ACT_REGISTER, 4'd1, 32'd7, 1'b0, 1'b0);
        push_word(ACT_REGISTER, 4'd1, 32'd1, 1'b1, 1'b1);            // overwrites the above
        push_word(ACT_REGISTER, 4'd2, 32'd2, 1'b1, 1'b0);
        push_word(ACT_HEARTBEAT, 4'd7, 32'hFFFF_FFFF, 1'b1, 1'b1);   // unregistered
        push_word(ACT_UNUSED, 4'hF, 32'hFFFF_FFFF, 1'b1, 1'b1);      // unused code
        wake_up();
        tick_n(4);
        push_word(ACT_HEARTBEAT, 4'd2, 32'd0, 1'b0, 1'b0);
        tick_n(7);
        // non-restartable channel ends the scan; channel 6 behind it is never reported
        push_word(ACT_REGISTER, 4'd5, 32'd1, 1'b0, 1'b0);
        push_word(ACT_REGISTER, 4'd6, 32'd1, 1'b1, 1'b1);
        tick_n(6);
    endtask

    // every channel expires in one scan; zero period scans on every tick
    task automatic test_full_scan();
        set_timing(16'd0, 16'd0);
        for (int i = 0; i < NCH; i++)
            push_word(ACT_REGISTER, 4'(i), 32'd1, 1'b1, 1'($urandom));
        wake_up();
        tick_n(8);
    endtask

    // receiver holds off while ticks keep coming, so the input stalls
    task automatic test_backpressure();
        for (int i = 0; i < NCH; i += 3)
            push_word(ACT_REGISTER, 4'(i), 32'd1, 1'b1, 1'b1);
        hold_left = HOLD_CYCLES;
        tick_n(12);
    endtask

    // largest period: one scan reloads the full count, the ticks after it stay silent
    task automatic test_long_period();
        set_timing(16'hFFFF, 16'd1);
        push_word(ACT_REGISTER, 4'd3, 32'd1, 1'b1, 1'b1);
        wake_up();
        tick_n(LONG_TICKS);
    endtask

    task automatic test_random();
        int          n;
        int          pick;
        int          seen;
        logic [3:0]  ch;
        logic [31:0] tmo;
        logic        rst_ok;
        n    = 0;
        set_timing(16'($urandom_range(1, 12)), 16'($urandom));
        wake_up();
        seen = sysrst_seen;
        while (n < RANDOM_WORDS) begin
            // every third stretch and the tail run without gaps
            src_idle_on  = (n < RANDOM_WORDS - QUIET_TAIL) && ((n / 40) % 3 != 2);
            sink_idle_on = src_idle_on;
            // a system reset restored the defaults: reprogram and wait for scans again
            if (sysrst_seen != seen) begin
                seen = sysrst_seen;
                set_timing(16'($urandom_range(1, 12)), 16'($urandom));
                wake_up();
            end
            pick = $urandom_range(0, 19);
            ch   = 4'($urandom);
            if (pick < 9) begin
                send_tick();
                n++;
            end else if (pick < 13) begin
                if (tbl_valid[ch])
                    n++;
                push_word(ACT_HEARTBEAT, ch, $urandom, 1'($urandom), 1'($urandom));
            end else if (pick < 19) begin
                case ($urandom_range(0, 9))
                    0:       tmo = 32'd0;
                    1:       tmo = $urandom;
                    2:       tmo = 32'hFFFF_FFFF;
                    default: tmo = $urandom_range(1, 30);
                endcase
                rst_ok = (sysrst_seen >= SYSRST_CAP) || ($urandom_range(0, 5) != 0);
                push_word(ACT_REGISTER, ch, tmo, rst_ok, 1'($urandom));
                n++;
            end else begin
                push_word(ACT_UNUSED, ch, $urandom, 1'($urandom), 1'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= ACT_TICK;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= ADDR_PERIOD;
        pwdata   <= '0;
        table_reset();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_defaults();
        test_directed();
        test_full_scan();
        test_backpressure();
        test_random();
        test_long_period();
        wait_drained();

        $display("run covered %0d input words and %0d scans, incl. zero and largest period",
                 words_sent, scans_run);
        $display("checked %0d event words: %0d restarts, %0d system resets",
                 events_checked, restarts_seen, sysrst_seen);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/mctw_pkg.sv
rtl/mctw_ram.sv
rtl/multi_channel_task_watchdog_core.sv
tb/multi_channel_task_watchdog_core_tb.sv
